// ===== hdl/moim_pkg.sv =====
// moim_pkg: constants, widths and controller state type for the
// masked overlap intensity mean unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package moim_pkg;
    localparam int COUNT_BITS   = 24;
    localparam int FRAC_BITS    = 8;
    localparam int MAG_BITS     = 9 + FRAC_BITS;
    localparam int CNT_OUT_BITS = COUNT_BITS + 1;
    localparam int SQ_BITS      = 18 + 2 * FRAC_BITS;
    localparam int ROOT_STEPS   = (SQ_BITS + 1) / 2;
    localparam int STEP_BITS    = $clog2(ROOT_STEPS + 1);
    localparam int SUM_BITS     = COUNT_BITS + MAG_BITS;
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int DIV_BITS     = $clog2(DIV_STEPS + 1);
    localparam logic [7:0] MASK_FULL = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROOT, ST_ACC, ST_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic root_start;
        logic root_step;
        logic acc;
        logic div_start;
        logic div_step;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic root_done;
        logic div_done;
        logic last;
    } stat_t;
endpackage
`default_nettype wire

// ===== hdl/moim_ctrl.sv =====
// moim_ctrl: controller state machine sequencing root, accumulate,
// divide and output; uses moim_pkg
`timescale 1ns / 1ps
`default_nettype none
module moim_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire moim_pkg::stat_t stat,
    output moim_pkg::cmd_t       cmd
);
    moim_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= moim_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            moim_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cmd.root_start = 1'b1;
                    state_next = moim_pkg::ST_ROOT;
                end
            end
            moim_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (stat.root_done) state_next = moim_pkg::ST_ACC;
            end
            moim_pkg::ST_ACC: begin
                cmd.acc = 1'b1;
                if (stat.last) begin
                    state_next = moim_pkg::ST_DIV;
                end else begin
                    state_next = moim_pkg::ST_IDLE;
                end
            end
            moim_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    state_next = moim_pkg::ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            moim_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.clear = 1'b1;
                    state_next = moim_pkg::ST_IDLE;
                end
            end
            default: state_next = moim_pkg::ST_IDLE;
        endcase
        cmd.div_start = (state_reg == moim_pkg::ST_ACC) && stat.last;
    end
endmodule
`default_nettype wire

// ===== hdl/moim_datapath.sv =====
// moim_datapath: squares, two bit-serial roots, accumulators and two
// restoring dividers, one per sum, sharing one divisor; uses moim_pkg
`timescale 1ns / 1ps
`default_nettype none
module moim_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [63:0]                        s_tdata,
    input  wire logic                               s_tlast,
    input  wire moim_pkg::cmd_t                     cmd,
    output moim_pkg::stat_t                         stat,
    output logic [moim_pkg::CNT_OUT_BITS-1:0]       count_out,
    output logic [moim_pkg::MAG_BITS-1:0]           mean_a_out,
    output logic [moim_pkg::MAG_BITS-1:0]           mean_b_out
);
    localparam int SQ = moim_pkg::SQ_BITS;
    localparam int RW = 2 * moim_pkg::ROOT_STEPS;
    localparam int SB = moim_pkg::SUM_BITS;
    localparam int CB = moim_pkg::CNT_OUT_BITS;

    logic [RW-1:0] rad_a_reg, rad_b_reg;
    logic [RW+1:0] rem_a_reg, rem_b_reg;
    logic [moim_pkg::MAG_BITS-1:0] root_a_reg, root_b_reg;
    logic [moim_pkg::STEP_BITS-1:0] rstep_reg;
    logic valid_reg, last_reg;
    logic [CB-1:0] cnt_reg;
    logic [SB-1:0] sum_a_reg, sum_b_reg;
    logic [SB-1:0] q_a_reg, q_b_reg;
    logic [CB:0] dr_a_reg, dr_b_reg;
    logic [CB-1:0] divisor_reg;
    logic [moim_pkg::DIV_BITS-1:0] dstep_reg;

    function automatic logic [SQ-1:0] sq3(input logic [7:0] r, g, b);
        logic [17:0] s;
        s = 18'(r * r) + 18'(g * g) + 18'(b * b);
        return SQ'(s) << (2 * moim_pkg::FRAC_BITS);
    endfunction

    logic [RW+1:0] trial_a, trial_b, sh_a, sh_b;
    always_comb begin
        sh_a = {rem_a_reg[RW-1:0], rad_a_reg[RW-1 -: 2]};
        sh_b = {rem_b_reg[RW-1:0], rad_b_reg[RW-1 -: 2]};
        trial_a = {(RW+2-moim_pkg::MAG_BITS-2)'(0), root_a_reg, 2'b01};
        trial_b = {(RW+2-moim_pkg::MAG_BITS-2)'(0), root_b_reg, 2'b01};
    end

    logic [CB:0] dsh_a, dsh_b;
    assign dsh_a = {dr_a_reg[CB-1:0], q_a_reg[SB-1]};
    assign dsh_b = {dr_b_reg[CB-1:0], q_b_reg[SB-1]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rad_a_reg <= RW'(sq3(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
            rad_b_reg <= RW'(sq3(s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]));
            valid_reg <= (s_tdata[55:48] == moim_pkg::MASK_FULL)
                      && (s_tdata[63:56] == moim_pkg::MASK_FULL);
            last_reg  <= s_tlast;
        end
        if (cmd.root_start) begin
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            root_a_reg <= '0;
            root_b_reg <= '0;
            rstep_reg <= '0;
        end else if (cmd.root_step) begin
            rad_a_reg <= rad_a_reg << 2;
            rad_b_reg <= rad_b_reg << 2;
            rstep_reg <= rstep_reg + 1'b1;
            if (sh_a >= trial_a) begin
                rem_a_reg <= sh_a - trial_a;
                root_a_reg <= {root_a_reg[moim_pkg::MAG_BITS-2:0], 1'b1};
            end else begin
                rem_a_reg <= sh_a;
                root_a_reg <= {root_a_reg[moim_pkg::MAG_BITS-2:0], 1'b0};
            end
            if (sh_b >= trial_b) begin
                rem_b_reg <= sh_b - trial_b;
                root_b_reg <= {root_b_reg[moim_pkg::MAG_BITS-2:0], 1'b1};
            end else begin
                rem_b_reg <= sh_b;
                root_b_reg <= {root_b_reg[moim_pkg::MAG_BITS-2:0], 1'b0};
            end
        end
        if (!aresetn || cmd.clear) begin
            cnt_reg <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end else if (cmd.acc && valid_reg && !cnt_reg[CB-1]) begin
            cnt_reg <= cnt_reg + 1'b1;
            sum_a_reg <= sum_a_reg + SB'(root_a_reg);
            sum_b_reg <= sum_b_reg + SB'(root_b_reg);
        end
        if (cmd.div_start) begin
            // accumulated value of this beat folded in here too
            if (valid_reg && !cnt_reg[CB-1]) begin
                q_a_reg <= sum_a_reg + SB'(root_a_reg);
                q_b_reg <= sum_b_reg + SB'(root_b_reg);
                divisor_reg <= cnt_reg + 1'b1;
            end else begin
                q_a_reg <= sum_a_reg;
                q_b_reg <= sum_b_reg;
                divisor_reg <= (cnt_reg == '0) ? CB'(1) : cnt_reg;
            end
            dr_a_reg <= '0;
            dr_b_reg <= '0;
            dstep_reg <= '0;
        end else if (cmd.div_step) begin
            dstep_reg <= dstep_reg + 1'b1;
            if (dsh_a >= {1'b0, divisor_reg}) begin
                dr_a_reg <= dsh_a - {1'b0, divisor_reg};
                q_a_reg <= {q_a_reg[SB-2:0], 1'b1};
            end else begin
                dr_a_reg <= dsh_a;
                q_a_reg <= {q_a_reg[SB-2:0], 1'b0};
            end
            if (dsh_b >= {1'b0, divisor_reg}) begin
                dr_b_reg <= dsh_b - {1'b0, divisor_reg};
                q_b_reg <= {q_b_reg[SB-2:0], 1'b1};
            end else begin
                dr_b_reg <= dsh_b;
                q_b_reg <= {q_b_reg[SB-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        stat.root_done = (rstep_reg == moim_pkg::STEP_BITS'(moim_pkg::ROOT_STEPS - 1));
        stat.div_done  = (dstep_reg == moim_pkg::DIV_BITS'(moim_pkg::DIV_STEPS));
        stat.last      = last_reg;
    end

    assign count_out  = divisor_reg;
    assign mean_a_out = q_a_reg[moim_pkg::MAG_BITS-1:0];
    assign mean_b_out = q_b_reg[moim_pkg::MAG_BITS-1:0];
endmodule
`default_nettype wire

// ===== hdl/masked_overlap_intensity_mean_unit.sv =====
// masked_overlap_intensity_mean_unit: top level joining controller and
// datapath; uses moim_pkg, moim_ctrl, moim_datapath
//
// one pixel pair is taken per beat; a pair counts when both masks are 255,
// and then the fixed-point rgb magnitude (8 fraction bits) of each pixel is
// added to its sum. a non-last beat passes through the load in idle, 17
// steps of the bit-serial square root and one accumulate. the beat marked
// last adds the restoring divides of both sums, run side by side on one
// shared divisor (41 steps and one to finish), then the result beat waits
// in its register until taken. the count saturates at 2^24 and a run with
// no counted pair reports a count of one.
`timescale 1ns / 1ps
`default_nettype none
module masked_overlap_intensity_mean_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // red_a, green_a, blue_a, red_b, green_b, blue_b, mask_a, mask_b
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tlast,   // last_pixel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // overlap_count[24:0], mean_a[41:25], mean_b[58:42], zero fill
    output logic [63:0]      m_tdata
);
    moim_pkg::cmd_t  cmd;
    moim_pkg::stat_t stat;
    logic [moim_pkg::CNT_OUT_BITS-1:0] cnt;
    logic [moim_pkg::MAG_BITS-1:0] ma, mb;

    moim_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .stat, .cmd
    );

    moim_datapath u_dp (
        .aclk, .aresetn, .s_tdata, .s_tlast, .cmd, .stat,
        .count_out(cnt), .mean_a_out(ma), .mean_b_out(mb)
    );

    assign m_tdata = {5'b0, mb, ma, cnt};
endmodule
`default_nettype wire

// ===== hdl/moim_checker.sv =====
// moim_checker: port-level assertions for the top level; bound to
// masked_overlap_intensity_mean_unit
`timescale 1ns / 1ps
`default_nettype none
module moim_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[24:0] != 25'd0) else $error("zero count");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready right after beat");
endmodule

bind masked_overlap_intensity_mean_unit moim_props u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
